/* rtl/tilt_sand_grain_update_assert.svh */
// Assertion macros for the sand grain update checker.
// Expects clk and rst in the scope of each use.
`ifndef TILT_SAND_GRAIN_UPDATE_ASSERT_SVH
`define TILT_SAND_GRAIN_UPDATE_ASSERT_SVH

// same-cycle implication
`define TSG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsg: same-cycle check failed");

// next-cycle implication
`define TSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsg: next-cycle check failed");

`endif

/* rtl/tsg_pkg.sv */
`timescale 1ns / 1ps
// tsg_pkg: types, constants and decode helpers of the sand grain update block.
// No dependencies; used by every RTL file of the block but tsg_ram.
package tsg_pkg;

  localparam int GRID     = 8;
  localparam int CW       = $clog2(GRID);
  localparam int GRAINS   = 64;
  localparam int GW       = $clog2(GRAINS);
  localparam int PW       = 1 + 2 * CW;
  localparam int ROWS     = 2 * GRID;
  localparam int RW       = $clog2(ROWS);
  localparam int SIDE_DEF = 8;
  localparam int QDEPTH   = 2;

  localparam int ICW = 16;
  localparam int ACW = 10;
  localparam int DZW = 9;
  localparam int AW  = 4;
  localparam int DW  = 32;

  localparam logic [ICW-1:0] INTERVAL_RST = 16'd281;
  localparam logic [ACW-1:0] CENTER_RST   = 10'd330;
  localparam logic [DZW-1:0] DEAD_RST     = 9'd40;

  localparam logic [AW-3:0] REG_INTERVAL = 2'd0;
  localparam logic [AW-3:0] REG_CENTER   = 2'd1;
  localparam logic [AW-3:0] REG_DEAD     = 2'd2;

  localparam logic MODE_STEP = 1'b1;

  typedef logic signed [1:0]    dir_t;
  typedef logic signed [CW+1:0] crd_t;

  localparam dir_t DIR_POS  = 2'sb01;
  localparam dir_t DIR_ZERO = 2'sb00;
  localparam dir_t DIR_NEG  = 2'sb11;

  typedef struct packed {
    dir_t dr;
    dir_t dc;
  } fall_t;

  typedef struct packed {
    logic step;
    dir_t dr;
    dir_t dc;
    logic coin;
  } item_t;

  typedef struct packed {
    logic          moved;
    logic [GW-1:0] grain;
    logic          from_grid;
    logic [CW-1:0] from_row;
    logic [CW-1:0] from_col;
    logic          to_grid;
    logic [CW-1:0] to_row;
    logic [CW-1:0] to_col;
    logic          crossed;
    logic          gate_status;
  } res_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_WR2} st_t;

  function automatic dir_t quantise(logic [ACW-1:0] raw, logic [ACW-1:0] center,
                                    logic [DZW-1:0] dz);
    logic signed [ACW:0] v;
    logic signed [ACW:0] d;
    v = $signed({1'b0, raw}) - $signed({1'b0, center});
    d = $signed({{(ACW-DZW+1){1'b0}}, dz});
    if (v < d && v > -d) return DIR_ZERO;
    else if (v >= d) return DIR_POS;
    else return DIR_NEG;
  endfunction

  function automatic fall_t fall_dir(dir_t qx, dir_t qy);
    fall_t f;
    f = '{DIR_ZERO, DIR_ZERO};
    case ({qx, qy})
      {DIR_POS,  DIR_POS }: f = '{DIR_ZERO, DIR_POS };
      {DIR_POS,  DIR_NEG }: f = '{DIR_NEG,  DIR_ZERO};
      {DIR_POS,  DIR_ZERO}: f = '{DIR_NEG,  DIR_POS };
      {DIR_NEG,  DIR_POS }: f = '{DIR_POS,  DIR_ZERO};
      {DIR_NEG,  DIR_NEG }: f = '{DIR_ZERO, DIR_NEG };
      {DIR_NEG,  DIR_ZERO}: f = '{DIR_POS,  DIR_NEG };
      {DIR_ZERO, DIR_POS }: f = '{DIR_POS,  DIR_POS };
      {DIR_ZERO, DIR_NEG }: f = '{DIR_NEG,  DIR_NEG };
      default:              f = '{DIR_ZERO, DIR_ZERO};
    endcase
    return f;
  endfunction

endpackage

/* rtl/tsg_ram.sv */
`timescale 1ns / 1ps
// tsg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tsg_front.sv */
`timescale 1ns / 1ps
// tsg_front: accepts requests, quantises the tilt samples into a fall direction
// and holds decoded requests in a short queue. Depends on tsg_pkg.
module tsg_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     mode,
  input  logic [tsg_pkg::ACW-1:0]  accel_x,
  input  logic [tsg_pkg::ACW-1:0]  accel_y,
  input  logic                     coin,
  input  logic [tsg_pkg::ACW-1:0]  accel_center,
  input  logic [tsg_pkg::DZW-1:0]  dead_zone,
  output logic                     q_valid,
  output tsg_pkg::item_t           q_item,
  input  logic                     q_pop
);
  import tsg_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             fifo [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              wr_en;
  logic              rd_en;
  dir_t              qx;
  dir_t              qy;
  fall_t             fall;
  item_t             item_in;

  always_comb begin
    qx           = quantise(accel_x, accel_center, dead_zone);
    qy           = quantise(accel_y, accel_center, dead_zone);
    fall         = fall_dir(qx, qy);
    item_in.step = (mode == MODE_STEP);
    item_in.dr   = fall.dr;
    item_in.dc   = fall.dc;
    item_in.coin = coin;
  end

  assign full    = (count == CNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = fifo[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo[wr_ptr] <= item_in;
    end
  end

endmodule

/* rtl/tsg_back.sv */
`timescale 1ns / 1ps
// tsg_back: runs ticks and grain steps against the position and occupancy RAMs
// and holds the finished result. Depends on tsg_pkg and tsg_ram.
module tsg_back #(
  parameter int SIDE = tsg_pkg::SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  tsg_pkg::item_t           q_item,
  output logic                     q_pop,
  input  logic [tsg_pkg::ICW-1:0]  interval,
  input  logic                     pop,
  output logic                     empty,
  output tsg_pkg::res_t            res
);
  import tsg_pkg::*;

  localparam int LIM = (SIDE < GRID) ? SIDE : GRID;

  function automatic logic inr(crd_t a, crd_t b);
    return (a >= 0) && (a < crd_t'(LIM)) && (b >= 0) && (b < crd_t'(LIM));
  endfunction

  st_t               state;
  st_t               state_next;
  logic [GW-1:0]     sweep;
  logic [GW-1:0]     sweep_next;
  logic [ICW-1:0]    elapsed;
  logic              gate;
  logic [GRAINS-1:0] place_valid;
  logic [ROWS-1:0]   row_valid;
  logic              prv;
  logic              rva;
  logic              rvb;
  logic              out_valid;
  res_t              out_res;

  logic [PW-1:0]     place_rdata;
  logic [PW-1:0]     place_q;
  logic [GRID-1:0]   occ_a_rdata;
  logic [GRID-1:0]   occ_b_rdata;
  logic [RW-1:0]     raddr_a;
  logic [RW-1:0]     raddr_b;

  logic              cur_g;
  logic [CW-1:0]     cur_r;
  logic [CW-1:0]     cur_c;
  crd_t              tr;
  crd_t              tc;
  logic              t_g;
  crd_t              t_r;
  crd_t              t_c;

  logic [GW-1:0]     s_idx;
  logic              s_g;
  logic [CW-1:0]     s_r;
  logic [CW-1:0]     s_c;
  logic              s_tg;
  crd_t              s_tr;
  crd_t              s_tc;
  logic              s_coin;

  logic [GRID-1:0]   row_a;
  logic [GRID-1:0]   row_b;
  logic [GRID-1:0]   new_a;
  logic [GRID-1:0]   new_b;
  logic              tgt_free;
  logic              kr;
  logic              kc;
  logic              use_row;
  logic              mv;
  logic              f_g;
  logic [CW-1:0]     f_r;
  logic [CW-1:0]     f_c;
  logic              same_row;
  logic              xed;

  logic [ICW:0]      tick_n;
  logic              tick_open;
  logic              slot_free;
  logic              start_step;

  logic              do_tick;
  logic              out_load;
  logic              place_we;
  logic              occ_we;
  logic [RW-1:0]     occ_waddr;
  logic [GRID-1:0]   occ_wdata;
  logic              gate_clear;
  logic              go_wr2;
  logic [RW-1:0]     wb_addr;
  logic [GRID-1:0]   wb_data;
  res_t              res_d;

  tsg_ram #(.WIDTH(PW), .DEPTH(GRAINS)) u_place (
    .clk   (clk),
    .we    (place_we),
    .waddr (s_idx),
    .wdata ({f_g, f_r, f_c}),
    .raddr (sweep_next),
    .rdata (place_rdata)
  );

  tsg_ram #(.WIDTH(GRID), .DEPTH(ROWS)) u_occ_a (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (raddr_a),
    .rdata (occ_a_rdata)
  );

  tsg_ram #(.WIDTH(GRID), .DEPTH(ROWS)) u_occ_b (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (raddr_b),
    .rdata (occ_b_rdata)
  );

  // dispatch and target lookup
  always_comb begin
    slot_free  = !out_valid || pop;
    start_step = (state == ST_IDLE) && q_valid && slot_free && q_item.step;
    sweep_next = (state == ST_EVAL) ? sweep + 1'b1 : sweep;

    place_q = prv ? place_rdata : PW'({1'b1, sweep});
    cur_g   = place_q[PW-1];
    cur_r   = place_q[2*CW-1:CW];
    cur_c   = place_q[CW-1:0];
    tr      = crd_t'({2'b00, cur_r}) + crd_t'(q_item.dr);
    tc      = crd_t'({2'b00, cur_c}) + crd_t'(q_item.dc);

    t_g = cur_g;
    t_r = tr;
    t_c = tc;
    if (!cur_g && tr == crd_t'(-1) && tc == crd_t'(GRID) && gate) begin
      t_g = 1'b1;
      t_r = crd_t'(GRID - 1);
      t_c = '0;
    end
    if (cur_g && tr == crd_t'(GRID) && tc == crd_t'(-1) && gate) begin
      t_g = 1'b0;
      t_r = '0;
      t_c = crd_t'(GRID - 1);
    end
    raddr_a = {cur_g, cur_r};
    raddr_b = {t_g, t_r[CW-1:0]};

    tick_n    = {1'b0, elapsed} + 1'b1;
    tick_open = (tick_n > {1'b0, interval});
  end

  // move decision
  always_comb begin
    row_a    = rva ? occ_a_rdata : {GRID{s_g}};
    row_b    = rvb ? occ_b_rdata : {GRID{s_tg}};
    tgt_free = inr(s_tr, s_tc) && !row_b[s_tc[CW-1:0]];
    kr       = inr(crd_t'({2'b00, s_r}), s_tc) && !row_a[s_tc[CW-1:0]];
    kc       = inr(s_tr, crd_t'({2'b00, s_c})) && !row_b[s_c];
    use_row  = kr && (!kc || s_coin);

    mv  = 1'b0;
    f_g = s_g;
    f_r = s_r;
    f_c = s_c;
    if (tgt_free) begin
      mv  = 1'b1;
      f_g = s_tg;
      f_r = s_tr[CW-1:0];
      f_c = s_tc[CW-1:0];
    end else if (s_tg == s_g) begin
      if (use_row) begin
        mv  = 1'b1;
        f_c = s_tc[CW-1:0];
      end else if (kc) begin
        mv  = 1'b1;
        f_r = s_tr[CW-1:0];
      end
    end
    same_row = (f_g == s_g) && (f_r == s_r);
    xed      = mv && (f_g != s_g);

    new_a      = row_a;
    new_a[s_c] = 1'b0;
    if (same_row) begin
      new_a[f_c] = 1'b1;
    end
    new_b      = row_b;
    new_b[f_c] = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_step) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = (mv && !same_row) ? ST_WR2 : ST_IDLE;
      end
      ST_WR2:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    do_tick    = 1'b0;
    out_load   = 1'b0;
    place_we   = 1'b0;
    occ_we     = 1'b0;
    occ_waddr  = {s_g, s_r};
    occ_wdata  = new_a;
    gate_clear = 1'b0;
    go_wr2     = 1'b0;
    res_d      = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (!q_item.step) begin
            do_tick           = 1'b1;
            out_load          = 1'b1;
            res_d.gate_status = tick_open || gate;
          end
        end
      end
      ST_EVAL: begin
        out_load          = 1'b1;
        place_we          = mv;
        occ_we            = mv;
        gate_clear        = xed;
        go_wr2            = mv && !same_row;
        res_d.moved       = mv;
        res_d.grain       = s_idx;
        res_d.from_grid   = s_g;
        res_d.from_row    = s_r;
        res_d.from_col    = s_c;
        res_d.to_grid     = f_g;
        res_d.to_row      = f_r;
        res_d.to_col      = f_c;
        res_d.crossed     = xed;
        res_d.gate_status = gate && !xed;
      end
      ST_WR2: begin
        occ_we    = 1'b1;
        occ_waddr = wb_addr;
        occ_wdata = wb_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sweep       <= '0;
      elapsed     <= '0;
      gate        <= 1'b0;
      place_valid <= '0;
      row_valid   <= '0;
      prv         <= 1'b0;
      rva         <= 1'b0;
      rvb         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      prv   <= place_valid[sweep_next];
      rva   <= row_valid[raddr_a];
      rvb   <= row_valid[raddr_b];
      if (do_tick) begin
        if (tick_open) begin
          gate    <= 1'b1;
          elapsed <= '0;
        end else begin
          elapsed <= tick_n[ICW-1:0];
        end
      end else if (gate_clear) begin
        gate <= 1'b0;
      end
      if (place_we) begin
        place_valid[s_idx] <= 1'b1;
      end
      if (occ_we) begin
        row_valid[occ_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_step) begin
      s_idx  <= sweep;
      s_g    <= cur_g;
      s_r    <= cur_r;
      s_c    <= cur_c;
      s_tg   <= t_g;
      s_tr   <= t_r;
      s_tc   <= t_c;
      s_coin <= q_item.coin;
    end
    if (go_wr2) begin
      wb_addr <= {f_g, f_r};
      wb_data <= new_b;
    end
    if (out_load) begin
      out_res <= res_d;
    end
  end

  assign empty = !out_valid;
  assign res   = out_res;

endmodule

/* rtl/tilt_sand_grain_update.sv */
`timescale 1ns / 1ps
// Hourglass of 64 sand grains on two 8x8 LED grids. A tick request is done in
// the idle state; a grain step adds an evaluate state, and a second write
// state when the grain leaves its LED row, since the occupancy rows then need
// two writes through the single write port of the occupancy RAM. A two-entry
// request queue after the direction decode and a one-entry result register
// let both sides stall independently. Grain positions live in a 64x7 RAM and
// occupancy in a 16x8 row RAM kept in two copies for two reads per step;
// per-entry valid bits stand in for the reset contents, so no clearing pass
// follows reset. Depends on tsg_pkg, tsg_front, tsg_back and tsg_ram.
module tilt_sand_grain_update #(
  parameter int SIDE = tsg_pkg::SIDE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [tsg_pkg::AW-1:0]  paddr,
  input  logic [tsg_pkg::DW-1:0]  pwdata,
  output logic [tsg_pkg::DW-1:0]  prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic                    mode,
  input  logic [tsg_pkg::ACW-1:0] accel_x,
  input  logic [tsg_pkg::ACW-1:0] accel_y,
  input  logic                    coin,
  output logic                    empty,
  input  logic                    pop,
  output logic                    moved,
  output logic [tsg_pkg::GW-1:0]  grain,
  output logic                    from_grid,
  output logic [tsg_pkg::CW-1:0]  from_row,
  output logic [tsg_pkg::CW-1:0]  from_col,
  output logic                    to_grid,
  output logic [tsg_pkg::CW-1:0]  to_row,
  output logic [tsg_pkg::CW-1:0]  to_col,
  output logic                    crossed,
  output logic                    gate_status
);
  import tsg_pkg::*;

  logic [ICW-1:0] interval_ticks;
  logic [ACW-1:0] accel_center;
  logic [DZW-1:0] dead_zone;
  logic           cfg_we;
  logic           q_valid;
  logic           q_pop;
  item_t          q_item;
  res_t           res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= INTERVAL_RST;
      accel_center   <= CENTER_RST;
      dead_zone      <= DEAD_RST;
    end else if (cfg_we) begin
      unique case (paddr[AW-1:2])
        REG_INTERVAL: interval_ticks <= pwdata[ICW-1:0];
        REG_CENTER:   accel_center   <= pwdata[ACW-1:0];
        REG_DEAD:     dead_zone      <= pwdata[DZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[AW-1:2])
      REG_INTERVAL: prdata = DW'(interval_ticks);
      REG_CENTER:   prdata = DW'(accel_center);
      REG_DEAD:     prdata = DW'(dead_zone);
      default:      prdata = '0;
    endcase
  end

  tsg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .coin         (coin),
    .accel_center (accel_center),
    .dead_zone    (dead_zone),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  tsg_back #(.SIDE(SIDE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .interval (interval_ticks),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign moved       = res.moved;
  assign grain       = res.grain;
  assign from_grid   = res.from_grid;
  assign from_row    = res.from_row;
  assign from_col    = res.from_col;
  assign to_grid     = res.to_grid;
  assign to_row      = res.to_row;
  assign to_col      = res.to_col;
  assign crossed     = res.crossed;
  assign gate_status = res.gate_status;

endmodule

/* rtl/tsg_checker.sv */
`timescale 1ns / 1ps
// tsg_checker: port-level checks on the result side of the sand grain update.
// Depends on tsg_pkg and tilt_sand_grain_update_assert.svh; bound to the top.
`include "tilt_sand_grain_update_assert.svh"

module tsg_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   empty,
  input logic                   pop,
  input logic                   moved,
  input logic [tsg_pkg::GW-1:0] grain,
  input logic                   from_grid,
  input logic [tsg_pkg::CW-1:0] from_row,
  input logic [tsg_pkg::CW-1:0] from_col,
  input logic                   to_grid,
  input logic [tsg_pkg::CW-1:0] to_row,
  input logic [tsg_pkg::CW-1:0] to_col,
  input logic                   crossed,
  input logic                   gate_status
);

  `TSG_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable({moved, grain, from_grid, from_row, from_col, to_grid, to_row, to_col, crossed, gate_status}))
  `TSG_ASSERT_NOW(a_still_same_cell, !empty && !moved, to_grid == from_grid && to_row == from_row && to_col == from_col && !crossed)
  `TSG_ASSERT_NOW(a_cross_closes_gate, !empty && crossed, moved && to_grid != from_grid && !gate_status)
  `TSG_ASSERT_NOW(a_move_keeps_grid, !empty && moved && !crossed, to_grid == from_grid)

endmodule

bind tilt_sand_grain_update tsg_checker u_tsg_checker (.*);

/* verif/tb_tilt_sand_grain_update.sv */
`timescale 1ns / 1ps
// Testbench for tilt_sand_grain_update: sends tick and grain step requests, predicts
// every LED update from its own copy of the hourglass, and checks each field.
// Depends on tsg_pkg and the RTL of the block; needs no files or arguments.
module tb_tilt_sand_grain_update;
  import tsg_pkg::*;

  localparam logic MODE_TICK   = ~MODE_STEP;
  localparam int   SIDE_LIM    = (SIDE_DEF < GRID) ? SIDE_DEF : GRID;
  localparam int   RAW_MAX     = (1 << ACW) - 1;
  localparam int   DRAIN_LAT   = 16;
  localparam int   QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic push = 1'b0, mode = 1'b0, coin = 1'b0, pop = 1'b0;
  logic [ACW-1:0] accel_x = '0, accel_y = '0;
  logic full, empty;
  logic moved, from_grid, to_grid, crossed, gate_status;
  logic [GW-1:0] grain;
  logic [CW-1:0] from_row, from_col, to_row, to_col;

  logic [ICW-1:0] cfg_interval = INTERVAL_RST;
  logic [ACW-1:0] cfg_center   = CENTER_RST;
  logic [DZW-1:0] cfg_dead     = DEAD_RST;
  bit             occ [2][GRID][GRID];
  logic [PW-1:0]  place [GRAINS];
  logic [GW-1:0]  sweep;
  logic [ICW-1:0] elapsed_ms;
  bit             gate_flag;
  res_t           pending_updates [$];

  int sender_idle_pct, receiver_stall_pct, mismatches, quiet_cycles;
  int ticks_sent, steps_sent, grains_moved, crossings, blocked_crossings;
  int gate_openings, coin_picks;

  tilt_sand_grain_update dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reset_hourglass();
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < GRID; r++)
        for (int c = 0; c < GRID; c++)
          occ[g][r][c] = (g == 1);
    for (int k = 0; k < GRAINS; k++)
      place[k] = PW'((1 << (2 * CW)) | ((k / GRID) << CW) | (k % GRID));
    sweep      = '0;
    elapsed_ms = '0;
    gate_flag  = 1'b0;
  endfunction

  function automatic int axis_level(logic [ACW-1:0] raw);
    int v, dz;
    v  = int'(raw) - int'(cfg_center);
    dz = int'(cfg_dead);
    if (v < dz && v > -dz) return 0;
    return (v >= dz) ? 1 : -1;
  endfunction

  function automatic bit cell_open(int g, int r, int c);
    if (r < 0 || c < 0 || r >= SIDE_LIM || c >= SIDE_LIM) return 1'b0;
    return occ[g][r][c] == 1'b0;
  endfunction

  function automatic res_t advance_hourglass(logic m, logic [ACW-1:0] ax,
                                             logic [ACW-1:0] ay, logic cn);
    res_t r;
    int qx, qy, dr, dc, g, rr, c, ng, nr, nc;
    logic [GW-1:0] idx;
    logic [ICW:0] nxt;
    bit mv, kr, kc;
    r = '0;
    if (m != MODE_STEP) begin
      ticks_sent++;
      nxt = {1'b0, elapsed_ms} + 1'b1;
      if (nxt > {1'b0, cfg_interval}) begin
        gate_flag  = 1'b1;
        elapsed_ms = '0;
        gate_openings++;
      end else begin
        elapsed_ms = nxt[ICW-1:0];
      end
      r.gate_status = gate_flag;
      return r;
    end
    steps_sent++;
    qx = axis_level(ax);
    qy = axis_level(ay);
    dr = 0;
    dc = 0;
    if (qx == 1) begin
      if (qy == 1) dc = 1;
      else if (qy == -1) dr = -1;
      else begin dr = -1; dc = 1; end
    end else if (qx == -1) begin
      if (qy == 1) dr = 1;
      else if (qy == -1) dc = -1;
      else begin dr = 1; dc = -1; end
    end else begin
      if (qy == 1) begin dr = 1; dc = 1; end
      else if (qy == -1) begin dr = -1; dc = -1; end
    end

    idx   = sweep;
    sweep = sweep + 1'b1;
    g  = int'(place[idx][PW-1]);
    rr = int'(place[idx][PW-2:CW]);
    c  = int'(place[idx][CW-1:0]);
    ng = g;
    nr = rr + dr;
    nc = c + dc;
    if (ng == 0 && nr == -1 && nc == GRID && gate_flag) begin
      ng = 1; nr = GRID - 1; nc = 0;
    end
    if (ng == 1 && nr == GRID && nc == -1 && gate_flag) begin
      ng = 0; nr = 0; nc = GRID - 1;
    end

    mv = 1'b0;
    if (cell_open(ng, nr, nc)) begin
      mv = 1'b1;
    end else if (ng == g) begin
      kr = cell_open(g, rr, nc);
      kc = cell_open(g, nr, c);
      if (kr && kc) begin
        coin_picks++;
        if (cn) kc = 1'b0;
        else kr = 1'b0;
      end
      if (kr) begin
        nr = rr;
        mv = 1'b1;
      end else if (kc) begin
        nc = c;
        mv = 1'b1;
      end
    end else begin
      blocked_crossings++;
    end

    if (mv) begin
      grains_moved++;
      occ[g][rr][c] = 1'b0;
      if (ng != g) begin
        r.crossed = 1'b1;
        gate_flag = 1'b0;
        crossings++;
      end
      occ[ng][nr][nc] = 1'b1;
      place[idx] = {ng[0], nr[CW-1:0], nc[CW-1:0]};
    end else begin
      ng = g; nr = rr; nc = c;
    end

    r.moved       = mv;
    r.grain       = idx;
    r.from_grid   = g[0];
    r.from_row    = rr[CW-1:0];
    r.from_col    = c[CW-1:0];
    r.to_grid     = ng[0];
    r.to_row      = nr[CW-1:0];
    r.to_col      = nc[CW-1:0];
    r.gate_status = gate_flag;
    return r;
  endfunction

  function automatic logic [ACW-1:0] pick_raw(dir_t q);
    int c, dz, lo, hi;
    c  = int'(cfg_center);
    dz = int'(cfg_dead);
    lo = 0;
    hi = -1;
    if (q == DIR_POS) begin
      lo = c + dz;
      hi = RAW_MAX;
    end else if (q == DIR_NEG) begin
      hi = c - ((dz == 0) ? 1 : dz);
    end else if (dz > 0) begin
      lo = (c - dz + 1 < 0) ? 0 : c - dz + 1;
      hi = (c + dz - 1 > RAW_MAX) ? RAW_MAX : c + dz - 1;
    end
    if (lo > hi) return ACW'($urandom_range(RAW_MAX));
    return ACW'($urandom_range(hi, lo));
  endfunction

  function automatic dir_t rand_dir();
    case ($urandom_range(2))
      0:       return DIR_ZERO;
      1:       return DIR_POS;
      default: return DIR_NEG;
    endcase
  endfunction

  task automatic send_request(input logic m, input logic [ACW-1:0] ax,
                              input logic [ACW-1:0] ay, input logic cn);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
      @(negedge clk);
    push    = 1'b1;
    mode    = m;
    accel_x = ax;
    accel_y = ay;
    coin    = cn;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_updates.push_back(advance_hourglass(m, ax, ay, cn));
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_tick();
    send_request(MODE_TICK, ACW'($urandom), ACW'($urandom), 1'($urandom));
  endtask

  task automatic send_step(input dir_t qx, input dir_t qy);
    send_request(MODE_STEP, pick_raw(qx), pick_raw(qy), 1'($urandom));
  endtask

  task automatic wait_drain();
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_LAT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [AW-3:0] index, input logic [DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_INTERVAL: cfg_interval = value[ICW-1:0];
      REG_CENTER:   cfg_center   = value[ACW-1:0];
      REG_DEAD:     cfg_dead     = value[DZW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_config(input int iv, input int ic, input int idz);
    wait_drain();
    write_reg(REG_INTERVAL, DW'(iv));
    write_reg(REG_CENTER, DW'(ic));
    write_reg(REG_DEAD, DW'(idz));
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_direction_decode();
    logic [ACW-1:0] levels [3];
    levels = '{ACW'(0), CENTER_RST, ACW'(RAW_MAX)};
    send_request(MODE_TICK, '0, '0, 1'b0);
    send_request(MODE_TICK, '1, '1, 1'b1);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        send_request(MODE_STEP, levels[i], levels[j], 1'((i + j) & 1));
    send_request(MODE_STEP, ACW'(CENTER_RST + DEAD_RST), CENTER_RST, 1'b0);
    send_request(MODE_STEP, ACW'(CENTER_RST + DEAD_RST - 1), CENTER_RST, 1'b1);
    send_request(MODE_STEP, CENTER_RST, ACW'(CENTER_RST - DEAD_RST), 1'b0);
    send_request(MODE_STEP, CENTER_RST, ACW'(CENTER_RST - DEAD_RST + 1), 1'b1);
  endtask

  task automatic test_gate_timer();
    apply_config(1, CENTER_RST, DEAD_RST);
    repeat (3) send_tick();
    apply_config(0, CENTER_RST, DEAD_RST);
    repeat (2) send_tick();
  endtask

  task automatic test_first_crossing();
    int guard;
    apply_config(2, CENTER_RST, DEAD_RST);
    guard = 0;
    while (crossings == 0 && guard < 200) begin
      if (!gate_flag) send_tick();
      else send_step(DIR_NEG, DIR_ZERO);
      guard++;
    end
  endtask

  task automatic test_timer_wrap();
    int guard;
    apply_config(65535, CENTER_RST, DEAD_RST);
    guard = 0;
    while (!gate_flag && guard < 32) begin
      send_tick();
      guard++;
    end
  endtask

  task automatic test_blocked_crossing();
    int guard;
    apply_config(2, CENTER_RST, DEAD_RST);
    guard = 0;
    while (blocked_crossings == 0 && guard < 400) begin
      if (!gate_flag) send_tick();
      else if (place[sweep] == {1'b0, CW'(0), CW'(GRID - 1)}) send_step(DIR_POS, DIR_POS);
      else send_step(DIR_NEG, DIR_ZERO);
      guard++;
    end
  endtask

  task automatic test_random_tilt(input int iv, input int ic, input int idz,
                                  input int spct, input int rpct, input int n);
    dir_t dx, dy;
    int pick;
    apply_config(iv, ic, idz);
    sender_idle_pct    = spct;
    receiver_stall_pct = rpct;
    dx = DIR_NEG;
    dy = DIR_ZERO;
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 0) begin
        pick = $urandom_range(9);
        if (pick < 4) begin
          dx = DIR_NEG;
          dy = DIR_ZERO;
        end else if (pick < 8) begin
          dx = DIR_POS;
          dy = DIR_ZERO;
        end else begin
          dx = rand_dir();
          dy = rand_dir();
        end
      end
      if (i == n / 2 || $urandom_range(99) == 0) wait_drain();
      pick = $urandom_range(99);
      if (pick < 30) send_tick();
      else if (pick < 85) send_step(dx, dy);
      else send_request(MODE_STEP, ACW'($urandom), ACW'($urandom), 1'($urandom));
    end
  endtask

  always @(negedge clk)
    pop <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin : led_update_check
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_updates.size() == 0) begin
        $error("LED update with no request outstanding");
        mismatches++;
      end else begin
        want = pending_updates.pop_front();
        compare_field("moved", 8'(want.moved), 8'(moved));
        compare_field("grain", 8'(want.grain), 8'(grain));
        compare_field("from_grid", 8'(want.from_grid), 8'(from_grid));
        compare_field("from_row", 8'(want.from_row), 8'(from_row));
        compare_field("from_col", 8'(want.from_col), 8'(from_col));
        compare_field("to_grid", 8'(want.to_grid), 8'(to_grid));
        compare_field("to_row", 8'(want.to_row), 8'(to_row));
        compare_field("to_col", 8'(want.to_col), 8'(to_col));
        compare_field("crossed", 8'(want.crossed), 8'(crossed));
        compare_field("gate_status", 8'(want.gate_status), 8'(gate_status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_hourglass();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_direction_decode();
    test_gate_timer();
    test_first_crossing();
    test_timer_wrap();
    test_blocked_crossing();
    test_random_tilt(2, 330, 40, 0, 0, 200);
    test_random_tilt(3, 512, 100, 84, 0, 200);
    test_random_tilt(1, 330, 40, 0, 84, 200);
    test_random_tilt(4, 700, 1, 35, 35, 200);
    test_random_tilt(2, 0, 0, 0, 0, 200);
    test_random_tilt(3, 1023, 511, 84, 0, 200);
    test_random_tilt(1, 200, 511, 0, 84, 200);
    test_random_tilt(5, 512, 0, 35, 35, 200);
    wait_drain();

    $display("Run covered %0d ticks and %0d grain steps: %0d moves, %0d coin-decided slides,",
             ticks_sent, steps_sent, grains_moved, coin_picks);
    $display("%0d grid crossings, %0d blocked crossings and %0d gate openings.",
             crossings, blocked_crossings, gate_openings);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
